// ===== rtl/ssel_pkg.sv =====
// ----------------------------------------------------------------------------
// ssel_pkg
// Shared types, codes and constants for the sensor source selector.
// ----------------------------------------------------------------------------
package ssel_pkg;

    localparam int MAX_BINDINGS_DEF = 8;
    localparam int CAPABILITIES_DEF = 4;
    localparam int LOCATIONS_DEF    = 4;

    // bindings that have entries in the hardware, priority and location tables
    localparam int TABLE_BINDINGS = 8;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic [2:0] REG_BINDINGS_USED  = 3'd0;
    localparam logic [2:0] REG_STALE_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_HARDWARE_MASK  = 3'd2;
    localparam logic [2:0] REG_PRIORITY_TABLE = 3'd3;
    localparam logic [2:0] REG_LOCATION_TABLE = 3'd4;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_ACTIVE = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    localparam logic [31:0] STALE_TIMEOUT_RST = 32'd60000;
    localparam logic [7:0]  PRIO_NONE         = 8'hFF;

    typedef struct packed {
        logic [3:0]  bindings_used;
        logic [31:0] stale_timeout_ms;
        logic [7:0]  hardware_mask;
        logic [63:0] priority_table;
        logic [15:0] location_table;
    } cfg_t;

endpackage

// ===== rtl/ssel_ram.sv =====
// ----------------------------------------------------------------------------
// ssel_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ssel_regs.sv =====
// ----------------------------------------------------------------------------
// ssel_regs
// APB configuration registers of the sensor source selector.
// ----------------------------------------------------------------------------
module ssel_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssel_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ssel_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ssel_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ssel_pkg::cfg_t                      cfg
);

    ssel_pkg::cfg_t cfg_reg;
    ssel_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ssel_pkg::REG_BINDINGS_USED:  cfg_next.bindings_used    = pwdata[3:0];
                ssel_pkg::REG_STALE_TIMEOUT:  cfg_next.stale_timeout_ms = pwdata[31:0];
                ssel_pkg::REG_HARDWARE_MASK:  cfg_next.hardware_mask    = pwdata[7:0];
                ssel_pkg::REG_PRIORITY_TABLE: cfg_next.priority_table   = pwdata;
                ssel_pkg::REG_LOCATION_TABLE: cfg_next.location_table   = pwdata[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ssel_pkg::REG_BINDINGS_USED:  prdata = 64'(cfg_reg.bindings_used);
            ssel_pkg::REG_STALE_TIMEOUT:  prdata = 64'(cfg_reg.stale_timeout_ms);
            ssel_pkg::REG_HARDWARE_MASK:  prdata = 64'(cfg_reg.hardware_mask);
            ssel_pkg::REG_PRIORITY_TABLE: prdata = cfg_reg.priority_table;
            ssel_pkg::REG_LOCATION_TABLE: prdata = 64'(cfg_reg.location_table);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bindings_used    <= '0;
            cfg_reg.stale_timeout_ms <= ssel_pkg::STALE_TIMEOUT_RST;
            cfg_reg.hardware_mask    <= '0;
            cfg_reg.priority_table   <= '0;
            cfg_reg.location_table   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/sensor_source_selector.sv =====
// ----------------------------------------------------------------------------
// sensor_source_selector
// Latest measurement store per binding and capability, with a query that
// picks the best fresh active source at a location.
//
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+------------------------------------
// config   | psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
// command  | start & !busy                  | kind, binding, capability, ...
// result   | done strobe, one cycle         | found, result_value, result_time,
//          |                                | source_binding
//
// Clear, store and set active complete at the accepting edge; busy stays low.
// A query scans one binding per cycle through the shared freshness and
// priority compare unit, fed by the entry RAM's registered read port,
// N = min(bindings_used, MAX_BINDINGS); busy in SCAN, DRAIN, DONE; done in DONE.
// An out-of-range query or N = 0 raises done in the cycle after acceptance.
// Reset clears valid and active flags; no clearing pass. Results cannot stall.
// ----------------------------------------------------------------------------
module sensor_source_selector #(
    parameter int MAX_BINDINGS = ssel_pkg::MAX_BINDINGS_DEF,
    parameter int CAPABILITIES = ssel_pkg::CAPABILITIES_DEF,
    parameter int LOCATIONS    = ssel_pkg::LOCATIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ssel_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ssel_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ssel_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      kind,
    input  logic [2:0]                      binding,
    input  logic [1:0]                      capability,
    input  logic [1:0]                      query_location,
    input  logic signed [31:0]              sample_value,
    input  logic [47:0]                     sample_time,
    input  logic [47:0]                     now,
    input  logic                            active,
    output logic                            done,
    output logic                            found,
    output logic signed [31:0]              result_value,
    output logic [47:0]                     result_time,
    output logic [2:0]                      source_binding
);

    localparam int SLOTS   = MAX_BINDINGS * CAPABILITIES;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BIND_W  = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
    localparam int IDX_W   = $clog2(MAX_BINDINGS + 1);
    localparam int ENTRY_W = 80;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    ssel_pkg::cfg_t cfg;

    state_t state_reg, state_next;
    logic [SLOTS-1:0]        valid_reg, valid_next;
    logic [MAX_BINDINGS-1:0] active_reg, active_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        count_reg, count_next;
    logic [1:0]              cap_reg, cap_next;
    logic [1:0]              loc_reg, loc_next;
    logic [47:0]             now_reg, now_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                    found_reg, found_next;
    logic                    sel_hw_reg, sel_hw_next;
    logic [7:0]              sel_prio_reg, sel_prio_next;
    logic [IDX_W-1:0]        sel_idx_reg, sel_idx_next;
    logic [31:0]             sel_value_reg, sel_value_next;
    logic [47:0]             sel_time_reg, sel_time_next;

    logic                    accept;
    logic                    bind_ok;
    logic                    cap_ok;
    logic [SLOT_W-1:0]       store_slot;
    logic [SLOT_W-1:0]       scan_slot;
    logic [ENTRY_W-1:0]      rd_entry;
    logic                    ram_we;
    logic [IDX_W-1:0]        count_calc;
    logic [2:0]              scan_lo;
    logic [1:0]              scan_loc;
    logic                    scan_qual;
    logic [2:0]              pend_lo;
    logic                    pend_hw;
    logic [7:0]              pend_prio;
    logic [48:0]             age;
    logic                    fresh;
    logic                    wins;

    ssel_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign accept     = start && !busy;
    assign bind_ok    = 32'(binding) < 32'(MAX_BINDINGS);
    assign cap_ok     = 32'(capability) < 32'(CAPABILITIES);
    assign store_slot = SLOT_W'(32'(binding) * CAPABILITIES + 32'(capability));
    assign scan_slot  = SLOT_W'(32'(idx_reg) * CAPABILITIES + 32'(cap_reg));
    assign ram_we     = accept && (kind == ssel_pkg::KIND_STORE) && bind_ok && cap_ok;

    ssel_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (store_slot),
        .wdata ({sample_time, sample_value}),
        .raddr (scan_slot),
        .rdata (rd_entry)
    );

    assign count_calc = (32'(cfg.bindings_used) > 32'(MAX_BINDINGS))
                        ? IDX_W'(MAX_BINDINGS) : IDX_W'(cfg.bindings_used);

    // scan side: location, active and valid checks at read issue
    assign scan_lo   = 3'(idx_reg);
    assign scan_loc  = (32'(idx_reg) < ssel_pkg::TABLE_BINDINGS)
                       ? cfg.location_table[2*scan_lo +: 2] : 2'd0;
    assign scan_qual = (scan_loc == loc_reg) && active_reg[BIND_W'(idx_reg)]
                       && valid_reg[scan_slot];

    // shared compare unit: freshness and priority of the entry just read
    assign pend_lo   = 3'(pend_idx_reg);
    assign pend_hw   = (32'(pend_idx_reg) < ssel_pkg::TABLE_BINDINGS)
                       ? cfg.hardware_mask[pend_lo] : 1'b0;
    assign pend_prio = (32'(pend_idx_reg) < ssel_pkg::TABLE_BINDINGS)
                       ? cfg.priority_table[8*pend_lo +: 8] : ssel_pkg::PRIO_NONE;
    assign age       = {1'b0, now_reg} - {1'b0, rd_entry[79:32]};
    assign fresh     = !age[48] && (age[47:0] <= {16'd0, cfg.stale_timeout_ms});
    assign wins      = !found_reg || (pend_hw && !sel_hw_reg)
                       || ((pend_hw == sel_hw_reg) && (pend_prio < sel_prio_reg));

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        loc_next       = loc_reg;
        now_next       = now_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        sel_hw_next    = sel_hw_reg;
        sel_prio_next  = sel_prio_reg;
        sel_idx_next   = sel_idx_reg;
        sel_value_next = sel_value_reg;
        sel_time_next  = sel_time_reg;

        if (pend_reg && fresh && wins)
        begin
            found_next     = 1'b1;
            sel_hw_next    = pend_hw;
            sel_prio_next  = pend_prio;
            sel_idx_next   = pend_idx_reg;
            sel_value_next = rd_entry[31:0];
            sel_time_next  = rd_entry[79:32];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        ssel_pkg::KIND_CLEAR:
                        begin
                            if (bind_ok)
                            begin
                                for (int c = 0; c < CAPABILITIES; c++)
                                begin
                                    valid_next[SLOT_W'(32'(binding) * CAPABILITIES + c)] = 1'b0;
                                end
                            end
                        end
                        ssel_pkg::KIND_STORE:
                        begin
                            if (bind_ok && cap_ok)
                            begin
                                valid_next[store_slot] = 1'b1;
                            end
                        end
                        ssel_pkg::KIND_ACTIVE:
                        begin
                            if (bind_ok)
                            begin
                                active_next[BIND_W'(binding)] = active;
                            end
                        end
                        ssel_pkg::KIND_QUERY:
                        begin
                            cap_next   = capability;
                            loc_next   = query_location;
                            now_next   = now;
                            count_next = count_calc;
                            idx_next   = '0;
                            found_next = 1'b0;
                            if (cap_ok && (32'(query_location) < 32'(LOCATIONS))
                                && (count_calc != '0))
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                pend_next     = scan_qual;
                pend_idx_next = idx_reg;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            active_reg <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            active_reg <= active_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        count_reg     <= count_next;
        cap_reg       <= cap_next;
        loc_reg       <= loc_next;
        now_reg       <= now_next;
        pend_idx_reg  <= pend_idx_next;
        sel_hw_reg    <= sel_hw_next;
        sel_prio_reg  <= sel_prio_next;
        sel_idx_reg   <= sel_idx_next;
        sel_value_reg <= sel_value_next;
        sel_time_reg  <= sel_time_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign found          = found_reg;
    assign result_value   = found_reg ? sel_value_reg : 32'sd0;
    assign result_time    = found_reg ? sel_time_reg : 48'd0;
    assign source_binding = found_reg ? 3'(sel_idx_reg) : 3'd0;

endmodule

// ===== test/sensor_source_selector_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_source_selector_tb
// Self-checking bench for the sensor source selector. Commands go in through
// start/busy, registers are set over APB while the block is idle, and each
// query result is compared field by field against an in-bench model of the
// measurement store and the source selection rules. A short directed run
// covers priority, hardware preference, ties, staleness and future stamps;
// randomized phases follow under several register settings.
// ----------------------------------------------------------------------------
module sensor_source_selector_tb;
    import ssel_pkg::*;

    localparam int SLOTS = MAX_BINDINGS_DEF * CAPABILITIES_DEF;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic               found;
        logic signed [31:0] value;
        logic [47:0]        stamp;
        logic [2:0]         src;
    } pick_t;

    class pick_scoreboard;
        cfg_t               regs;
        logic signed [31:0] slot_value [SLOTS];
        logic [47:0]        slot_stamp [SLOTS];
        bit                 slot_valid [SLOTS];
        bit                 bind_on [MAX_BINDINGS_DEF];
        pick_t              pending_picks [$];
        int                 errors;

        function new();
            regs = '0;
            regs.stale_timeout_ms = STALE_TIMEOUT_RST;
            foreach (slot_valid[s]) slot_valid[s] = 0;
            foreach (bind_on[b]) bind_on[b] = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_BINDINGS_USED:  regs.bindings_used = data[3:0];
                REG_STALE_TIMEOUT:  regs.stale_timeout_ms = data[31:0];
                REG_HARDWARE_MASK:  regs.hardware_mask = data[7:0];
                REG_PRIORITY_TABLE: regs.priority_table = data;
                REG_LOCATION_TABLE: regs.location_table = data[15:0];
                default: ;
            endcase
        endfunction

        function bit is_fresh(int s, logic [47:0] at);
            if (!slot_valid[s] || slot_stamp[s] > at)
                return 0;
            return (at - slot_stamp[s]) <= {16'd0, regs.stale_timeout_ms};
        endfunction

        function pick_t best_source(logic [1:0] cap, logic [1:0] loc, logic [47:0] at);
            pick_t      p;
            int         n;
            int         s;
            bit         hw;
            bit         sel_hw;
            logic [7:0] pr;
            logic [7:0] sel_prio;
            p = '0;
            sel_hw = 0;
            sel_prio = PRIO_NONE;
            n = (regs.bindings_used > MAX_BINDINGS_DEF) ? MAX_BINDINGS_DEF
                                                        : int'(regs.bindings_used);
            for (int i = 0; i < n; i++)
            begin
                s = i * CAPABILITIES_DEF + cap;
                if (regs.location_table[2*i +: 2] != loc || !bind_on[i] || !is_fresh(s, at))
                    continue;
                hw = regs.hardware_mask[i];
                pr = regs.priority_table[8*i +: 8];
                if (!p.found || (hw && !sel_hw) || (hw == sel_hw && pr < sel_prio))
                begin
                    p.found = 1;
                    p.value = slot_value[s];
                    p.stamp = slot_stamp[s];
                    p.src = i[2:0];
                    sel_hw = hw;
                    sel_prio = pr;
                end
            end
            return p;
        endfunction

        function void note_command(logic [1:0] k, logic [2:0] b, logic [1:0] cap,
                                   logic [1:0] loc, logic signed [31:0] val,
                                   logic [47:0] stamp, logic [47:0] at, logic act);
            int s;
            s = b * CAPABILITIES_DEF + cap;
            case (k)
                KIND_CLEAR:
                    for (int c = 0; c < CAPABILITIES_DEF; c++)
                        slot_valid[b * CAPABILITIES_DEF + c] = 0;
                KIND_STORE:
                begin
                    slot_value[s] = val;
                    slot_stamp[s] = stamp;
                    slot_valid[s] = 1;
                end
                KIND_ACTIVE: bind_on[b] = act;
                default: pending_picks.push_back(best_source(cap, loc, at));
            endcase
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(pick_t got);
            pick_t want;
            if (pending_picks.size() == 0)
            begin
                $display("%0t: result with no query pending, actual %0h", $time, got);
                errors++;
                return;
            end
            want = pending_picks.pop_front();
            compare("found", 64'(want.found), 64'(got.found));
            compare("result_value", 64'(unsigned'(want.value)), 64'(unsigned'(got.value)));
            compare("result_time", 64'(want.stamp), 64'(got.stamp));
            compare("source_binding", 64'(want.src), 64'(got.src));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   start;
    logic                   busy;
    logic [1:0]             kind;
    logic [2:0]             binding;
    logic [1:0]             capability;
    logic [1:0]             query_location;
    logic signed [31:0]     sample_value;
    logic [47:0]            sample_time;
    logic [47:0]            now;
    logic                   active;
    logic                   done;
    logic                   found;
    logic signed [31:0]     result_value;
    logic [47:0]            result_time;
    logic [2:0]             source_binding;

    pick_scoreboard sb;
    bit             no_gaps;
    logic [47:0]    clock_ms;

    sensor_source_selector uut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({found, result_value, result_time, source_binding});
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 3'b000};
        pwdata = data;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    task automatic send_cmd(input logic [1:0] k, input logic [2:0] b, input logic [1:0] cap,
                            input logic [1:0] loc, input logic signed [31:0] val,
                            input logic [47:0] stamp, input logic [47:0] at,
                            input logic act);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        kind = k;
        binding = b;
        capability = cap;
        query_location = loc;
        sample_value = val;
        sample_time = stamp;
        now = at;
        active = act;
        start = 1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(k, b, cap, loc, val, stamp, at, act);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // wait for all query results, then out the longest scan
    task automatic drain();
        start = 0;
        while (sb.pending_picks.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic configure(input int p);
        logic [63:0] prio;
        for (int i = 0; i < 8; i++)
            prio[8*i +: 8] = p[0] ? 8'($urandom_range(0, 3)) : 8'($urandom);
        case (p)
            0:
            begin
                write_reg(REG_BINDINGS_USED, 8);
                write_reg(REG_STALE_TIMEOUT, 0);
                write_reg(REG_HARDWARE_MASK, 8'h00);
                write_reg(REG_PRIORITY_TABLE, 64'h0);
            end
            1:
            begin
                write_reg(REG_BINDINGS_USED, 0);
                write_reg(REG_STALE_TIMEOUT, 32'hFFFF_FFFF);
                write_reg(REG_HARDWARE_MASK, 8'hFF);
                write_reg(REG_PRIORITY_TABLE, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            2:
            begin
                write_reg(REG_BINDINGS_USED, 15);
                write_reg(REG_STALE_TIMEOUT, 32'hFFFF_FFFF);
                write_reg(REG_HARDWARE_MASK, 64'($urandom));
                write_reg(REG_PRIORITY_TABLE, prio);
            end
            default:
            begin
                write_reg(REG_BINDINGS_USED, 64'($urandom_range(1, 8)));
                write_reg(REG_STALE_TIMEOUT, 64'($urandom_range(0, 2500)));
                write_reg(REG_HARDWARE_MASK, 64'($urandom));
                write_reg(REG_PRIORITY_TABLE, prio);
            end
        endcase
        write_reg(REG_LOCATION_TABLE, (p == 2) ? 64'h0 : 64'(16'($urandom)));
    endtask

    task automatic random_command();
        int          r;
        logic [1:0]  k;
        logic [47:0] stamp;
        logic [47:0] at;
        r = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 40);
        k = (r < 8) ? KIND_CLEAR : (r < 50) ? KIND_STORE : (r < 62) ? KIND_ACTIVE : KIND_QUERY;
        case ($urandom_range(0, 9))
            0, 1: stamp = clock_ms;
            2: stamp = clock_ms + $urandom_range(1, 50);
            9: stamp = 48'({$urandom, $urandom});
            default: stamp = clock_ms - $urandom_range(0, 3000);
        endcase
        at = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) : clock_ms;
        send_cmd(k, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), $urandom, stamp, at,
                 $urandom_range(0, 3) != 0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        start = 0;
        kind = KIND_CLEAR;
        binding = '0;
        capability = '0;
        query_location = '0;
        sample_value = '0;
        sample_time = '0;
        now = '0;
        active = 0;
        no_gaps = 0;
        clock_ms = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // no bindings in use after reset: nothing can be found
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1000, 0);
        drain();

        write_reg(REG_BINDINGS_USED, 8);
        write_reg(REG_STALE_TIMEOUT, 100);
        write_reg(REG_HARDWARE_MASK, 8'b0000_1110);
        write_reg(REG_PRIORITY_TABLE, 64'hFF00_0000_0303_0905);
        write_reg(REG_LOCATION_TABLE, 16'h0000);
        for (int b = 0; b < 4; b++)
            send_cmd(KIND_ACTIVE, 3'(b), 0, 0, 0, 0, 0, 1);
        send_cmd(KIND_ACTIVE, 7, 0, 0, 0, 0, 0, 1);
        send_cmd(KIND_STORE, 0, 0, 0, 32'sh7FFF_FFFF, 48'd1000, 0, 0);
        send_cmd(KIND_STORE, 1, 0, 0, 32'sh8000_0000, 48'd1000, 0, 0);
        send_cmd(KIND_STORE, 2, 0, 0, 0, 48'd1050, 0, 0);
        // hardware, lower priority wins
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1050, 0);
        // equal priority: earlier index stays
        send_cmd(KIND_STORE, 3, 0, 0, -5, 48'd1060, 0, 0);
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1060, 0);
        // future stamps skipped
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1040, 0);
        // stale entries skipped
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1101, 0);
        send_cmd(KIND_QUERY, 0, 0, 1, 0, 0, 48'd1060, 0);
        send_cmd(KIND_CLEAR, 2, 0, 0, 0, 0, 0, 0);
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1060, 0);
        send_cmd(KIND_ACTIVE, 3, 0, 0, 0, 0, 0, 0);
        send_cmd(KIND_QUERY, 0, 0, 0, 0, 0, 48'd1060, 0);
        send_cmd(KIND_STORE, 7, 3, 0, 32'sh1234_5678, 48'hFFFF_FFFF_FFFF, 0, 0);
        send_cmd(KIND_QUERY, 0, 3, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 0);
        send_cmd(KIND_QUERY, 0, 3, 0, 0, 0, 48'd0, 0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            configure(p);
            clock_ms = (p == 3) ? 48'hFFFF_FFFF_F000 : 48'({$urandom, $urandom});
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                no_gaps = (i % 64) < 16;
                if (p == 4 && i == PHASE_ITEMS / 2)
                    drain();
                random_command();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_picks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
